### rtl/fvcc_pkg.sv
// ----------------------------------------------------------------------------
// fvcc_pkg
// Shared constants and tables for the flow vector colour coder: angle format,
// arctangent steps for the angle pipeline and the 55-entry colour wheel.
// ----------------------------------------------------------------------------
package fvcc_pkg;

   localparam int FLOW_W       = 16;
   localparam int MM_W         = 15;
   localparam int BYTE_W       = 8;
   localparam int ANG_BITS     = 20;
   localparam int CORDIC_STEPS = 16;
   localparam int WHEEL_SIZE   = 55;
   localparam int WHEEL_IDX_W  = 6;
   localparam int WHEEL_MUL    = WHEEL_SIZE - 1;

   localparam logic [MM_W-1:0]       MM_RESET    = 15'd2560;
   localparam logic [ANG_BITS-1:0]   ANG_HALF    = 20'h80000;
   localparam logic [ANG_BITS-2:0]   ANG_QUARTER = 19'h40000;

   // arctangent of 2^-i in 2^-20 turn
   localparam logic [17:0] ATAN_TAB [CORDIC_STEPS] = '{
      18'd131072, 18'd77376, 18'd40884, 18'd20753, 18'd10417, 18'd5213,
      18'd2607,   18'd1304,  18'd652,   18'd326,   18'd163,   18'd81,
      18'd41,     18'd20,    18'd10,    18'd5
   };

   typedef logic [3*BYTE_W-1:0] wheel_tab_type [WHEEL_SIZE];

   // built at elaboration: entry is {red, green, blue}
   function automatic wheel_tab_type wheel_build();
      wheel_tab_type t;
      int r, g, b, i;
      for (int k = 0; k < WHEEL_SIZE; k++) begin
         if (k < 15) begin
            i = k;      r = 255;                g = 255 * i / 15;       b = 0;
         end else if (k < 21) begin
            i = k - 15; r = 255 - 255 * i / 6;  g = 255;                b = 0;
         end else if (k < 25) begin
            i = k - 21; r = 0;                  g = 255;                b = 255 * i / 4;
         end else if (k < 36) begin
            i = k - 25; r = 0;                  g = 255 - 255 * i / 11; b = 255;
         end else if (k < 49) begin
            i = k - 36; r = 255 * i / 13;       g = 0;                  b = 255;
         end else begin
            i = k - 49; r = 255;                g = 0;                  b = 255 - 255 * i / 6;
         end
         t[k] = {8'(r), 8'(g), 8'(b)};
      end
      return t;
   endfunction

   localparam wheel_tab_type WHEEL_TAB = wheel_build();

endpackage

### rtl/fvcc_req_if.sv
// ----------------------------------------------------------------------------
// fvcc_req_if
// Flow vector channel: one word per pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fvcc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] flow_x;
   logic signed [15:0] flow_y;
   logic               flow_valid;

   modport source (output valid, flow_x, flow_y, flow_valid, input ready);
   modport sink   (input valid, flow_x, flow_y, flow_valid, output ready);
endinterface

### rtl/fvcc_rsp_if.sv
// ----------------------------------------------------------------------------
// fvcc_rsp_if
// Colour channel: one BGR word per pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fvcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, blue, green, red, input ready);
   modport sink   (input valid, blue, green, red, output ready);
endinterface

### rtl/fvcc_delay.sv
// ----------------------------------------------------------------------------
// fvcc_delay
// Enabled shift line that lines the colour path up with the radius path.
// ----------------------------------------------------------------------------
module fvcc_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] d_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            d_ff[i] <= d_ff[i-1];
         end
      end
   end

   assign dout = d_ff[DEPTH-1];
endmodule

### rtl/fvcc_cordic.sv
// ----------------------------------------------------------------------------
// fvcc_cordic
// Vectoring CORDIC, one rotation per stage, giving the first-quadrant angle
// of (ax, ay) in 2^-20 turn with the axis cases forced.
// ----------------------------------------------------------------------------
module fvcc_cordic #(
   parameter int SIDE_W = 2
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [fvcc_pkg::FLOW_W-1:0]     ax,
   input  logic [fvcc_pkg::FLOW_W-1:0]     ay,
   input  logic [SIDE_W-1:0]               side_in,
   output logic [fvcc_pkg::ANG_BITS-2:0]   alpha,
   output logic [SIDE_W-1:0]               side_out
);
   import fvcc_pkg::*;

   localparam int XW = FLOW_W + 7;
   localparam int ZW = ANG_BITS + 1;
   localparam int N  = CORDIC_STEPS;
   localparam int SW = SIDE_W + 2;

   logic signed [XW-1:0] xs [N];
   logic signed [XW-1:0] ys [N];
   logic signed [ZW-1:0] zs [N+1];
   logic [SW-1:0]        ss [N+1];
   logic signed [ZW-1:0] z_last;
   logic                 y_zero;
   logic                 x_zero;

   assign xs[0] = signed'({3'b000, ax, 4'b0000});
   assign ys[0] = signed'({3'b000, ay, 4'b0000});
   assign zs[0] = '0;
   assign ss[0] = {ay == '0, ax == '0, side_in};

   for (genvar s = 0; s < N; s++) begin : g_step
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;
      logic signed [ZW-1:0] z_ff;
      logic [SW-1:0]        s_ff;
      logic signed [ZW-1:0] at;

      assign at = signed'(ZW'(ATAN_TAB[s]));

      always_comb begin
         if (!ys[s][XW-1]) begin
            x_in = xs[s] + (ys[s] >>> s);
            y_in = ys[s] - (xs[s] >>> s);
            z_in = zs[s] + at;
         end else begin
            x_in = xs[s] - (ys[s] >>> s);
            y_in = ys[s] + (xs[s] >>> s);
            z_in = zs[s] - at;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff <= z_in;
            s_ff <= ss[s];
         end
      end

      assign zs[s+1] = z_ff;
      assign ss[s+1] = s_ff;

      if (s < N - 1) begin : g_xy
         logic signed [XW-1:0] x_ff;
         logic signed [XW-1:0] y_ff;

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff <= x_in;
               y_ff <= y_in;
            end
         end

         assign xs[s+1] = x_ff;
         assign ys[s+1] = y_ff;
      end
   end

   assign z_last   = zs[N];
   assign y_zero   = ss[N][SW-1];
   assign x_zero   = ss[N][SW-2];
   assign side_out = ss[N][SIDE_W-1:0];

   always_comb begin
      priority if (y_zero) begin
         alpha = '0;
      end else if (x_zero) begin
         alpha = ANG_QUARTER;
      end else if (z_last[ZW-1]) begin
         alpha = '0;
      end else if (z_last > signed'(ZW'(ANG_QUARTER))) begin
         alpha = ANG_QUARTER;
      end else begin
         alpha = z_last[ANG_BITS-2:0];
      end
   end
endmodule

### rtl/fvcc_sqrt.sv
// ----------------------------------------------------------------------------
// fvcc_sqrt
// Pipelined integer square root, one root bit per stage (restoring form).
// ----------------------------------------------------------------------------
module fvcc_sqrt #(
   parameter int IN_W   = 48,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IN_W-1:0]     radicand,
   input  logic [SIDE_W-1:0]   side_in,
   output logic [IN_W/2-1:0]   root,
   output logic [SIDE_W-1:0]   side_out
);
   localparam int RW = IN_W / 2;
   localparam int MW = RW + 1;
   localparam int TW = RW + 3;

   logic [IN_W-1:0]   ns [RW];
   logic [MW-1:0]     ms [RW];
   logic [RW-1:0]     qs [RW+1];
   logic [SIDE_W-1:0] ss [RW+1];

   assign ns[0] = radicand;
   assign ms[0] = '0;
   assign qs[0] = '0;
   assign ss[0] = side_in;

   for (genvar s = 0; s < RW; s++) begin : g_bit
      logic [TW-1:0]     rt;
      logic [TW-1:0]     tr;
      logic [MW-1:0]     m_in;
      logic [RW-1:0]     q_in;
      logic [RW-1:0]     q_ff;
      logic [SIDE_W-1:0] s_ff;

      assign rt = {ms[s], ns[s][IN_W-1 -: 2]};
      assign tr = {1'b0, qs[s], 2'b01};

      always_comb begin
         if (rt >= tr) begin
            m_in = MW'(rt - tr);
            q_in = {qs[s][RW-2:0], 1'b1};
         end else begin
            m_in = MW'(rt);
            q_in = {qs[s][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff <= q_in;
            s_ff <= ss[s];
         end
      end

      assign qs[s+1] = q_ff;
      assign ss[s+1] = s_ff;

      if (s < RW - 1) begin : g_rem
         logic [MW-1:0]   m_ff;
         logic [IN_W-1:0] n_ff;

         always_ff @(posedge clock) begin
            if (en) begin
               m_ff <= m_in;
               n_ff <= {ns[s][IN_W-3:0], 2'b00};
            end
         end

         assign ms[s+1] = m_ff;
         assign ns[s+1] = n_ff;
      end
   end

   assign root     = qs[RW];
   assign side_out = ss[RW];
endmodule

### rtl/fvcc_div.sv
// ----------------------------------------------------------------------------
// fvcc_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit Q_W bits for the result to be meaningful.
// ----------------------------------------------------------------------------
module fvcc_div #(
   parameter int NUM_W  = 24,
   parameter int DEN_W  = 15,
   parameter int Q_W    = 9,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [Q_W-1:0]    quo,
   output logic [SIDE_W-1:0] side_out
);
   localparam int EW = NUM_W + DEN_W + Q_W;

   logic [NUM_W-1:0]  rs [Q_W];
   logic [DEN_W-1:0]  ds [Q_W];
   logic [Q_W-1:0]    qs [Q_W+1];
   logic [SIDE_W-1:0] ss [Q_W+1];

   assign rs[0] = num;
   assign ds[0] = den;
   assign qs[0] = '0;
   assign ss[0] = side_in;

   for (genvar s = 0; s < Q_W; s++) begin : g_bit
      localparam int B = Q_W - 1 - s;
      logic [EW-1:0]     sub;
      logic              ge;
      logic [Q_W-1:0]    q_ff;
      logic [SIDE_W-1:0] s_ff;

      assign sub = EW'(ds[s]) << B;
      assign ge  = EW'(rs[s]) >= sub;

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff <= {qs[s][Q_W-2:0], ge};
            s_ff <= ss[s];
         end
      end

      assign qs[s+1] = q_ff;
      assign ss[s+1] = s_ff;

      if (s < Q_W - 1) begin : g_rem
         logic [NUM_W-1:0] r_ff;
         logic [DEN_W-1:0] d_ff;

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff <= ge ? NUM_W'(EW'(rs[s]) - sub) : rs[s];
               d_ff <= ds[s];
            end
         end

         assign rs[s+1] = r_ff;
         assign ds[s+1] = d_ff;
      end
   end

   assign quo      = qs[Q_W];
   assign side_out = ss[Q_W];
endmodule

### rtl/flow_vector_color_coding.sv
// ----------------------------------------------------------------------------
// flow_vector_color_coding
// Optical flow to colour wheel coder: angle by CORDIC, radius by square root
// and division, blend toward white inside max_motion, dimmed beyond it.
//
//   channel   dir  handshake        word
//   req_bus   in   valid/ready      flow_x, flow_y (Q7.8), flow_valid
//   rsp_bus   out  valid/ready      blue, green, red
//   csr_*     in   write enable     max_motion (15 bit, Q7.8)
//
// One word per clock while the output word is taken; the radius path runs
// through the root stages (16 + F) followed by the quotient stages (F + 1).
// Reset clears the valid bits of every stage and loads max_motion = 10.0.
// The whole pipe advances together; when the output word is held and not
// taken, every stage holds and req_bus.ready drops.
// ----------------------------------------------------------------------------
module flow_vector_color_coding #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [fvcc_pkg::MM_W-1:0]    csr_wdata,
   fvcc_req_if.sink                     req_bus,
   fvcc_rsp_if.source                   rsp_bus
);
   import fvcc_pkg::*;

   localparam int F    = FRACTION_BITS;
   localparam int LAT  = 22 + 2 * F;
   localparam int CW   = BYTE_W + F;
   localparam int RW   = 16 + F;
   localparam int QW   = F + 1;
   localparam int PW   = QW + CW;
   localparam int DLY  = 1 + 2 * F;
   localparam int POSW = ANG_BITS + WHEEL_IDX_W;

   logic              en;
   logic [LAT-1:0]    vld_ff;
   logic [MM_W-1:0]   mm_ff;

   // stage A
   logic [FLOW_W-1:0] ax_a_ff, ay_a_ff;
   logic              sx_a_ff, sy_a_ff, fv_a_ff;
   logic [MM_W-1:0]   m_a_ff;

   // angle path
   logic [ANG_BITS-2:0] alpha;
   logic [1:0]          sgn;
   logic [ANG_BITS-1:0] phi;
   logic [POSW-1:0]     pos_in, pos_ff;
   logic [WHEEL_IDX_W-1:0] k0, k1;
   logic [F-1:0]        frac;
   logic [3*BYTE_W-1:0] e0, e1;
   logic [CW-1:0]       c_in [3];
   logic [CW-1:0]       c_ff [3];
   logic [3*CW-1:0]     c_d;

   // radius path
   logic [2*FLOW_W-1:0] ax2_b_ff, ay2_b_ff;
   logic [2*MM_W-1:0]   m2_b_ff;
   logic [MM_W-1:0]     m_b_ff;
   logic                fv_b_ff;
   logic [2*FLOW_W-1:0] r2_c_ff;
   logic                in_c_ff, fv_c_ff;
   logic [MM_W-1:0]     m_c_ff;
   logic [RW-1:0]       root;
   logic [MM_W+1:0]     sq_side;
   logic [QW-1:0]       rq;
   logic [1:0]          dv_side;

   // blend
   logic [PW-1:0]       prod_ff [3];
   logic [CW-1:0]       cp_ff [3];
   logic                fv_p_ff, in_p_ff;
   logic [BYTE_W-1:0]   byte_in [3];
   logic [BYTE_W-1:0]   byte_ff [3];

   assign en            = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign rsp_bus.valid = vld_ff[LAT-1];
   assign rsp_bus.red   = byte_ff[0];
   assign rsp_bus.green = byte_ff[1];
   assign rsp_bus.blue  = byte_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         mm_ff  <= MM_RESET;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
         end
         if (csr_we) begin
            mm_ff <= csr_wdata;
         end
      end
   end

   // ---------------- stage A: magnitudes ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         ax_a_ff <= req_bus.flow_x[FLOW_W-1] ? FLOW_W'(-req_bus.flow_x) : req_bus.flow_x;
         ay_a_ff <= req_bus.flow_y[FLOW_W-1] ? FLOW_W'(-req_bus.flow_y) : req_bus.flow_y;
         sx_a_ff <= req_bus.flow_x[FLOW_W-1];
         sy_a_ff <= req_bus.flow_y[FLOW_W-1];
         fv_a_ff <= req_bus.flow_valid;
         m_a_ff  <= (mm_ff == '0) ? MM_W'(1) : mm_ff;
      end
   end

   // ---------------- angle path ----------------
   fvcc_cordic #(.SIDE_W(2)) u_cordic (
      .clock    (clock),
      .en       (en),
      .ax       (ax_a_ff),
      .ay       (ay_a_ff),
      .side_in  ({sx_a_ff, sy_a_ff}),
      .alpha    (alpha),
      .side_out (sgn)
   );

   always_comb begin
      unique case (sgn)
         2'b00:   phi = ANG_BITS'(alpha);
         2'b10:   phi = ANG_HALF - ANG_BITS'(alpha);
         2'b11:   phi = ANG_HALF + ANG_BITS'(alpha);
         default: phi = ANG_BITS'(0) - ANG_BITS'(alpha);
      endcase
      pos_in = POSW'(phi) * POSW'(WHEEL_MUL);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
      end
   end

   assign k0   = pos_ff[POSW-1:ANG_BITS];
   assign k1   = (k0 == WHEEL_IDX_W'(WHEEL_SIZE - 1)) ? '0 : k0 + 1'b1;
   assign frac = pos_ff[ANG_BITS-1 -: F];
   assign e0   = WHEEL_TAB[k0];
   assign e1   = WHEEL_TAB[k1];

   // channel 0 red, 1 green, 2 blue
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         c_in[ch] = CW'(e0[(2-ch)*BYTE_W +: BYTE_W]) * CW'((QW'(1) << F) - QW'(frac))
                  + CW'(e1[(2-ch)*BYTE_W +: BYTE_W]) * CW'(frac);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
      end
   end

   fvcc_delay #(.W(3*CW), .DEPTH(DLY)) u_cdelay (
      .clock (clock),
      .en    (en),
      .din   ({c_ff[0], c_ff[1], c_ff[2]}),
      .dout  (c_d)
   );

   // ---------------- radius path ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         ax2_b_ff <= ax_a_ff * ax_a_ff;
         ay2_b_ff <= ay_a_ff * ay_a_ff;
         m2_b_ff  <= m_a_ff * m_a_ff;
         m_b_ff   <= m_a_ff;
         fv_b_ff  <= fv_a_ff;
         r2_c_ff  <= ax2_b_ff + ay2_b_ff;
         in_c_ff  <= (ax2_b_ff + ay2_b_ff) <= (2*FLOW_W)'(m2_b_ff);
         m_c_ff   <= m_b_ff;
         fv_c_ff  <= fv_b_ff;
      end
   end

   fvcc_sqrt #(.IN_W(2*RW), .SIDE_W(MM_W+2)) u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand ({r2_c_ff, (2*F)'(0)}),
      .side_in  ({fv_c_ff, in_c_ff, m_c_ff}),
      .root     (root),
      .side_out (sq_side)
   );

   fvcc_div #(.NUM_W(RW), .DEN_W(MM_W), .Q_W(QW), .SIDE_W(2)) u_div (
      .clock    (clock),
      .en       (en),
      .num      (root),
      .den      (sq_side[MM_W-1:0]),
      .side_in  (sq_side[MM_W+1:MM_W]),
      .quo      (rq),
      .side_out (dv_side)
   );

   // ---------------- blend ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 3; ch++) begin
            cp_ff[ch]   <= c_d[(2-ch)*CW +: CW];
            prod_ff[ch] <= PW'(rq) *
                           PW'((CW'(255) << F) - c_d[(2-ch)*CW +: CW]);
         end
         fv_p_ff <= dv_side[1];
         in_p_ff <= dv_side[0];
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic [PW-1:0]   v;
         logic [CW+1:0]   d3;
         v  = (PW'(255) << (2*F)) - prod_ff[ch];
         d3 = (CW+2)'(cp_ff[ch]) * (CW+2)'(3);
         if (!fv_p_ff) begin
            byte_in[ch] = '0;
         end else if (in_p_ff) begin
            byte_in[ch] = v[2*F +: BYTE_W];
         end else begin
            byte_in[ch] = d3[F+2 +: BYTE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         byte_ff <= byte_in;
      end
   end

   // ---------------- checks ----------------
   a_reset_empty: assert property (@(posedge clock) reset |=> vld_ff == '0)
      else $error("pipe not empty after reset");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(vld_ff) == $past($countones(vld_ff))
         + int'($past(req_bus.valid && req_bus.ready))
         - int'($past(rsp_bus.valid && rsp_bus.ready)))
      else $error("word lost or duplicated in pipe");

   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-3] && dv_side[1] && dv_side[0] |-> rq <= (QW'(1) << F))
      else $error("radius quotient above one");

   a_dim_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && en && fv_p_ff && !in_p_ff |=>
         rsp_bus.red <= 8'd191 && rsp_bus.green <= 8'd191 && rsp_bus.blue <= 8'd191)
      else $error("dimmed colour too bright");
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the flow vector colour coder. Flow words go in through the
// request channel and the colour words that come back are checked against
// a predictor. The run covers several max_motion settings, including the
// extremes. Both sides idle at random, and the sink stalls once for long.
// ----------------------------------------------------------------------------
module tb_top;
   import fvcc_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } bgr_type;

   class colour_scoreboard;
      bgr_type          colour_q[$];
      logic [MM_W-1:0]  max_motion = MM_RESET;
      int               errors = 0;
      int               words_in = 0;

      static function longint fshr(longint v, int s);
         return v >>> s;
      endfunction

      static function longint root64(longint n);
         longint r, b;
         r = 0;
         b = longint'(1) << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // wheel entry as {blue, green, red}
      static function bgr_type hue(int k);
         int r, g, b, i;
         if (k < 15) begin
            i = k; r = 255; g = 255 * i / 15; b = 0;
         end else if (k < 21) begin
            i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
         end else if (k < 25) begin
            i = k - 21; r = 0; g = 255; b = 255 * i / 4;
         end else if (k < 36) begin
            i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
         end else if (k < 49) begin
            i = k - 36; r = 255 * i / 13; g = 0; b = 255;
         end else begin
            i = k - 49; r = 255; g = 0; b = 255 - 255 * i / 6;
         end
         return '{blue: 8'(b), green: 8'(g), red: 8'(r)};
      endfunction

      static function longint octant_angle(longint ax, longint ay);
         longint atan_steps [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
                                     1304, 652, 326, 163, 81, 41, 20, 10, 5};
         longint cx, cy, z, nx;
         if (ay == 0) return 0;
         if (ax == 0) return longint'(1) << (ANG_BITS - 2);
         cx = ax * 16;
         cy = ay * 16;
         z = 0;
         for (int i = 0; i < 16; i++) begin
            if (cy >= 0) begin
               nx = cx + fshr(cy, i);
               cy = cy - fshr(cx, i);
               z += atan_steps[i];
            end else begin
               nx = cx - fshr(cy, i);
               cy = cy + fshr(cx, i);
               z -= atan_steps[i];
            end
            cx = nx;
         end
         if (z < 0) z = 0;
         if (z > (longint'(1) << (ANG_BITS - 2))) z = longint'(1) << (ANG_BITS - 2);
         return z;
      endfunction

      function bgr_type colour_of(logic signed [FLOW_W-1:0] fx,
                                  logic signed [FLOW_W-1:0] fy, logic fv);
         longint x, y, ax, ay, alpha, phi, pos, m, r2, rq, c, v, byt;
         int k0, k1, fr;
         bit in_range;
         bgr_type e0, e1, res;
         logic [7:0] ch0 [3];
         logic [7:0] ch1 [3];
         logic [7:0] outb [3];
         if (!fv) return '0;
         x = fx;
         y = fy;
         ax = x < 0 ? -x : x;
         ay = y < 0 ? -y : y;
         alpha = octant_angle(ax, ay);
         if (x >= 0 && y >= 0) phi = alpha;
         else if (x < 0 && y >= 0) phi = (longint'(1) << 19) - alpha;
         else if (x < 0) phi = (longint'(1) << 19) + alpha;
         else phi = (longint'(1) << 20) - alpha;
         phi = phi & ((longint'(1) << 20) - 1);
         pos = phi * (WHEEL_SIZE - 1);
         k0 = int'(pos >> 20);
         if (k0 >= WHEEL_SIZE) k0 = WHEEL_SIZE - 1;
         k1 = (k0 + 1) % WHEEL_SIZE;
         fr = int'((pos >> 12) & 255);
         m = max_motion ? longint'(max_motion) : 1;
         r2 = ax * ax + ay * ay;
         in_range = r2 <= m * m;
         rq = 0;
         if (in_range) begin
            rq = root64(r2 << 16) / m;
            if (rq > 256) rq = 256;
         end
         e0 = hue(k0);
         e1 = hue(k1);
         ch0 = '{e0.blue, e0.green, e0.red};
         ch1 = '{e1.blue, e1.green, e1.red};
         for (int ch = 0; ch < 3; ch++) begin
            c = longint'(ch0[ch]) * (256 - fr) + longint'(ch1[ch]) * fr;
            if (in_range) begin
               v = (longint'(255) << 16) - rq * ((longint'(255) << 8) - c);
               byt = v >> 16;
            end else begin
               byt = (3 * c) >> 10;
            end
            if (byt > 255) byt = 255;
            outb[ch] = 8'(byt);
         end
         res.blue = outb[0];
         res.green = outb[1];
         res.red = outb[2];
         return res;
      endfunction

      function void note_flow(logic signed [FLOW_W-1:0] fx, logic signed [FLOW_W-1:0] fy,
                              logic fv);
         colour_q.insert(colour_q.size(), colour_of(fx, fy, fv));
         words_in++;
      endfunction

      function void check_colour(bgr_type got);
         bgr_type want;
         if (colour_q.size() == 0) begin
            $display("%0t: colour word %h with none expected", $time, got);
            errors++;
            return;
         end
         want = colour_q.pop_front();
         if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
            errors++;
         end
         if (got.green !== want.green) begin
            $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
            errors++;
         end
         if (got.red !== want.red) begin
            $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
            errors++;
         end
      endfunction
   endclass

   localparam int LATENCY   = 38;
   localparam int MAX_CYCLE = 400000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_we = 1'b0;
   logic [MM_W-1:0] csr_wdata = '0;
   bit              calm = 0;
   int              cycles = 0;

   colour_scoreboard sb = new();

   fvcc_req_if req ();
   fvcc_rsp_if rsp ();

   flow_vector_color_coding dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req),
      .rsp_bus   (rsp)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         sb.note_flow(req.flow_x, req.flow_y, req.flow_valid);
      if (!reset && rsp.valid && rsp.ready)
         sb.check_colour('{blue: rsp.blue, green: rsp.green, red: rsp.red});
   end

   // sink side: short random stalls, plus one long hold-off to fill the pipe
   int  stall_left = 0;
   bit  held_long = 0;
   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      if (!held_long && sb.words_in >= 300) begin
         held_long = 1;
         stall_left = 150;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_flow(logic signed [FLOW_W-1:0] fx, logic signed [FLOW_W-1:0] fy,
                            logic fv);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.flow_x     <= fx;
      req.flow_y     <= fy;
      req.flow_valid <= fv;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain_and_set(logic [MM_W-1:0] mm);
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.colour_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mm;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.max_motion = mm;
   endtask

   function automatic logic signed [FLOW_W-1:0] near_radius(int mm);
      int mag;
      mag = $urandom_range(0, 2 * (mm == 0 ? 1 : mm) + 2);
      if (mag > 32767) mag = 32767;
      return $urandom_range(0, 1) ? FLOW_W'(-mag) : FLOW_W'(mag);
   endfunction

   task automatic random_words(int n, int mm);
      logic signed [FLOW_W-1:0] fx, fy;
      int mode;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 3) begin
            fx = FLOW_W'($urandom());
            fy = FLOW_W'($urandom());
         end else if (mode < 8) begin
            fx = near_radius(mm);
            fy = near_radius(mm);
         end else if (mode == 8) begin
            fx = $urandom_range(0, 1) ? near_radius(mm) : 16'sd0;
            fy = fx == 0 ? near_radius(mm) : 16'sd0;
         end else begin
            fx = near_radius(mm);
            fy = $urandom_range(0, 1) ? fx : -fx;
         end
         send_flow(fx, fy, $urandom_range(0, 7) != 0);
      end
   endtask

   logic [MM_W-1:0] mm_list [6];

   initial begin
      req.valid      = 1'b0;
      req.flow_x     = '0;
      req.flow_y     = '0;
      req.flow_valid = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset setting
      send_flow(16'sd0, 16'sd0, 1'b1);
      send_flow(16'sd1234, -16'sd77, 1'b0);
      send_flow(-16'sd1, -16'sd1, 1'b0);
      send_flow(16'sd32767, 16'sd0, 1'b1);
      send_flow(-16'sd32768, 16'sd0, 1'b1);
      send_flow(16'sd0, 16'sd32767, 1'b1);
      send_flow(16'sd0, -16'sd32768, 1'b1);
      send_flow(-16'sd32768, -16'sd32768, 1'b1);
      send_flow(16'sd32767, 16'sd32767, 1'b1);
      send_flow(16'sd32767, -16'sd32768, 1'b1);
      send_flow(-16'sd32768, 16'sd32767, 1'b1);
      send_flow(16'sd2560, 16'sd0, 1'b1);
      send_flow(16'sd2561, 16'sd0, 1'b1);
      send_flow(16'sd0, -16'sd2560, 1'b1);
      send_flow(16'sd1810, 16'sd1810, 1'b1);
      send_flow(-16'sd1811, 16'sd1811, 1'b1);
      send_flow(16'sd1, 16'sd0, 1'b1);
      send_flow(-16'sd1, 16'sd0, 1'b1);
      send_flow(16'sd100, -16'sd1, 1'b1);
      send_flow(16'sd100, 16'sd1, 1'b1);

      mm_list = '{MM_RESET, 15'd1, 15'h7FFF, 15'd0, 15'd256, 15'($urandom_range(2, 32766))};
      foreach (mm_list[p]) begin
         if (p != 0) drain_and_set(mm_list[p]);
         if (p == 5) calm = 1;
         random_words(p == 5 ? 140 : 260, mm_list[p]);
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.colour_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
